### src/ow_pkg.sv
// Shared types and constants for the 1-Wire bus master.
// No dependencies; every other file in src imports this package.
package ow_pkg;

  localparam int LenW    = 10;
  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;

  typedef logic [LenW-1:0] ow_len_t;
  typedef ow_len_t [NumRegs-1:0] ow_regs_t;

  // Register indexes on the configuration port
  localparam logic [RegIdxW-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_RESET_WAIT   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_WRITE_LOW    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_WRITE_BIT    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_READ_HIGH    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_READ_LOW     = 3'd5;
  localparam logic [RegIdxW-1:0] REG_READ_SAMPLE  = 3'd6;
  localparam logic [RegIdxW-1:0] REG_READ_RECOVER = 3'd7;

  localparam ow_regs_t REG_RESET_VALS = '{
    7: 10'd60, 6: 10'd5, 5: 10'd3, 4: 10'd2,
    3: 10'd45, 2: 10'd15, 1: 10'd500, 0: 10'd750
  };

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } ow_op_t;

  typedef struct packed {
    ow_op_t      op;
    logic [2:0]  phase;
    ow_len_t     count;
    logic [2:0]  bit_idx;
    logic [7:0]  shift;
    logic [7:0]  received;
  } ow_state_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy;
    logic       done;
    logic [7:0] read_value;
  } ow_res_t;

endpackage

### src/ow_if.sv
// Request channels of the 1-Wire bus master: command, result and configuration.
// Depends on ow_pkg.
interface ow_cmd_if;
  import ow_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] write_value;
  logic       line_level;
  modport source(output valid, action, write_value, line_level, input ready);
  modport sink(input valid, action, write_value, line_level, output ready);
endinterface

interface ow_res_if;
  import ow_pkg::*;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  modport source(output valid, drive_enable, drive_level, busy_res, done_res, read_value,
                 input ready);
  modport sink(input valid, drive_enable, drive_level, busy_res, done_res, read_value,
               output ready);
endinterface

interface ow_cfg_if;
  import ow_pkg::*;
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  ow_len_t            data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/ow_cfg.sv
// Timing register file; gives each phase length with zero read as one tick.
// Depends on ow_pkg.
module ow_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [ow_pkg::RegIdxW-1:0] wr_index,
  input  ow_pkg::ow_len_t           wr_data,
  output ow_pkg::ow_regs_t          lens
);
  import ow_pkg::*;

  ow_regs_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET_VALS;
    end else if (wr_en) begin
      regs[wr_index] <= wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NumRegs; i++) begin
      lens[RegIdxW'(i)] = (regs[RegIdxW'(i)] == '0) ? ow_len_t'(1) : regs[RegIdxW'(i)];
    end
  end

endmodule

### src/ow_step.sv
// One tick of the bus sequencer: next state and the line drive for this tick.
// Depends on ow_pkg.
module ow_step (
  input  ow_pkg::ow_state_t cur,
  input  ow_pkg::ow_regs_t  lens,
  input  logic [1:0]        action,
  input  logic [7:0]        write_value,
  input  logic              line_level,
  output ow_pkg::ow_state_t nxt,
  output ow_pkg::ow_res_t   res
);
  import ow_pkg::*;

  ow_state_t st;
  ow_len_t   len;
  ow_len_t   cnt1;
  logic      last_phase;
  logic      phase_end;

  always_comb begin
    st = cur;
    // start a command only from idle
    if (cur.op == OP_IDLE && action != 2'(OP_IDLE)) begin
      st.op      = ow_op_t'(action);
      st.phase   = '0;
      st.count   = '0;
      st.bit_idx = '0;
      st.shift   = (ow_op_t'(action) == OP_WRITE) ? write_value : 8'h00;
    end

    last_phase = 1'b0;
    len        = ow_len_t'(1);
    res        = '0;

    unique case (st.op)
      OP_RESET: begin
        if (st.phase == 3'd0) begin
          res.drive_enable = 1'b1;
          res.drive_level  = 1'b1;
        end else if (st.phase == 3'd1) begin
          len              = lens[REG_RESET_LOW];
          res.drive_enable = 1'b1;
        end else begin
          len        = lens[REG_RESET_WAIT];
          last_phase = 1'b1;
        end
      end
      OP_WRITE: begin
        res.drive_enable = 1'b1;
        if (st.phase == 3'd0) begin
          len = lens[REG_WRITE_LOW];
        end else if (st.phase == 3'd1) begin
          len             = lens[REG_WRITE_BIT];
          res.drive_level = st.shift[0];
        end else begin
          res.drive_level = 1'b1;
          last_phase      = 1'b1;
        end
      end
      OP_READ: begin
        if (st.phase == 3'd0) begin
          len              = lens[REG_READ_HIGH];
          res.drive_enable = 1'b1;
          res.drive_level  = 1'b1;
        end else if (st.phase == 3'd1) begin
          len              = lens[REG_READ_LOW];
          res.drive_enable = 1'b1;
        end else if (st.phase == 3'd2) begin
          len = lens[REG_READ_SAMPLE];
        end else begin
          len        = lens[REG_READ_RECOVER];
          last_phase = 1'b1;
        end
      end
      OP_IDLE: begin
      end
      default: begin
      end
    endcase

    nxt       = st;
    cnt1      = st.count + ow_len_t'(1);
    phase_end = (cnt1 >= len) || (cnt1 == '0);

    if (st.op != OP_IDLE) begin
      res.busy  = 1'b1;
      nxt.count = cnt1;
      if (phase_end) begin
        nxt.count = '0;
        if (st.op == OP_READ && st.phase == 3'd2) begin
          nxt.shift = {line_level, st.shift[7:1]};
        end
        if (!last_phase) begin
          nxt.phase = st.phase + 3'd1;
        end else if (st.op == OP_RESET || st.bit_idx == LAST_BIT) begin
          if (st.op == OP_READ) begin
            nxt.received = nxt.shift;
          end
          res.done    = 1'b1;
          nxt.op      = OP_IDLE;
          nxt.phase   = '0;
          nxt.bit_idx = '0;
        end else begin
          if (st.op == OP_WRITE) begin
            nxt.shift = {1'b0, st.shift[7:1]};
          end
          nxt.bit_idx = st.bit_idx + 3'd1;
          nxt.phase   = '0;
        end
      end
    end

    if (!res.drive_enable) begin
      res.drive_level = 1'b0;
    end
    res.read_value = nxt.received;
  end

endmodule

### src/one_wire_bus_master_unit.sv
// Top level of the 1-Wire bus master: sequencer state, result register, handshakes.
// Depends on ow_pkg, ow_if.sv, ow_cfg and ow_step.
//
// Every command request is one microsecond tick and yields exactly one result
// request describing the bus during that tick (drive enable and level, busy,
// done, last byte read). One tick is taken per clock cycle unless the result
// channel stalls: the sequencer state and the result register update together
// on acceptance, and a new tick is accepted whenever the result register is
// empty or being drained, so each result shows in the cycle after its tick
// is accepted. A start action (reset, write byte, read byte) is honoured only
// while idle; it is ignored while a command runs. The eight timing registers may be rewritten at any
// time through the configuration channel; a zero length counts as one tick.
// The presence pulse after a bus reset is not checked.
module one_wire_bus_master_unit (
  input  logic     clk,
  input  logic     rst,
  ow_cmd_if.sink   cmd,
  ow_res_if.source rsp,
  ow_cfg_if.sink   cfg
);
  import ow_pkg::*;

  ow_state_t state;
  ow_state_t state_next;
  ow_res_t   step_res;
  ow_regs_t  lens;
  logic      out_valid;
  ow_res_t   out_res;
  logic      accept;

  // config writes never stall
  assign cfg.ready = 1'b1;

  ow_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .lens     (lens)
  );

  ow_step u_step (
    .cur         (state),
    .lens        (lens),
    .action      (cmd.action),
    .write_value (cmd.write_value),
    .line_level  (cmd.line_level),
    .nxt         (state_next),
    .res         (step_res)
  );

  // take a tick while the result slot is free or emptying this cycle
  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= step_res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.drive_enable = out_res.drive_enable;
  assign rsp.drive_level  = out_res.drive_level;
  assign rsp.busy_res     = out_res.busy;
  assign rsp.done_res     = out_res.done;
  assign rsp.read_value   = out_res.read_value;

  // a finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && step_res.done) |=> (state.op == OP_IDLE))
    else $error("sequencer not idle after done");

  // an accepted tick always presents a result next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result");

  // idle with no start action: line released and not busy
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && state.op == OP_IDLE && cmd.action == 2'(OP_IDLE))
      |=> (!rsp.busy_res && !rsp.drive_enable))
    else $error("idle tick drove the bus");

  // released line never reports a driven level
  a_level_masked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.drive_enable) |-> !rsp.drive_level)
    else $error("drive level set while released");

endmodule
